[rtl/core/bdrs_pkg.sv]
// Shared types and constants for the block-decomposed range-sum core.
// Used by the core, its block divider and its port checker; no dependencies.
package bdrs_pkg;

   localparam int IDX_W   = 10;
   localparam int COUNT_W = 11;
   localparam int DATA_W  = 32;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int BLOCK_LEN_DEF    = 32;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         left;
      logic [IDX_W-1:0]         right;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] range_sum;
      logic                     status;
   } rsp_type;

endpackage

[rtl/core/block_decomposed_range_sum_core.sv]
// Range-sum core over a store of signed 32-bit elements with one running sum per block
// of BLOCK_LEN elements. After reset the core sweeps both stores to zero, one entry a
// cycle, and holds busy high meanwhile. A load splits its index in the block divider,
// reads the old element, forms the difference and writes the element and its block
// sum; a query splits its left bound in the divider, then reads the elements of the
// partial blocks at either end and one block sum per whole block, and its result
// appears as the core returns to idle. Busy stays high until each is done; the pace
// is set by the block divider and by the single read port of each store. A load out
// of range is dropped without leaving idle, and a bad query answers on the next
// cycle with status set and a zero sum. Each result is shown for one cycle under
// rsp_strobe and cannot be held off, so the receiver must take it when it appears.
module block_decomposed_range_sum_core
   import bdrs_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   parameter int BLOCK_LEN    = BLOCK_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_payload,
   output logic               rsp_strobe,
   output rsp_type            rsp_payload,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata
);

   localparam int AW          = $clog2(MAX_ELEMENTS);
   localparam int BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN;
   localparam int BLK_W       = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int OFF_W       = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
   localparam int REM_W       = $clog2(BLOCK_LEN + 1);
   localparam int POS_W       = IDX_W + 1;
   localparam int SPAN_W      = $clog2((1 << IDX_W) + BLOCK_LEN) + 1;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_LD_RD, ST_LD_DIFF, ST_LD_WR, ST_WALK
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               pend_ff, pend_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [COUNT_W-1:0] csr_ff, csr_in;

   req_type            req_ff, req_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic               pend_blk_ff, pend_blk_in;
   logic [DATA_W-1:0]  diff_ff, diff_in;
   rsp_type            rsp_ff, rsp_in;

   logic [DATA_W-1:0]  elem_mem [MAX_ELEMENTS];
   logic [DATA_W-1:0]  bsum_mem [BLOCK_COUNT];
   logic [DATA_W-1:0]  elem_rd_ff, bsum_rd_ff;
   logic               elem_we, bsum_we;
   logic [AW-1:0]      elem_waddr, elem_raddr;
   logic [BLK_W-1:0]   bsum_waddr, bsum_raddr;
   logic [DATA_W-1:0]  elem_wdata, bsum_wdata;

   logic               div_go, div_done;
   logic [IDX_W-1:0]   div_dividend, div_quot;
   logic [REM_W-1:0]   div_rem;

   logic [COUNT_W-1:0] live;
   logic               accept;
   logic               load_ok, query_bad;
   logic               in_range, whole;
   logic [DATA_W-1:0]  addend;

   bdrs_div #(.BLOCK_LEN(BLOCK_LEN)) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dividend),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // count in effect: register value limited to the store depth
   always_comb begin
      live = csr_ff;
      if (MAX_ELEMENTS < (1 << COUNT_W)) begin
         if (csr_ff > COUNT_W'(MAX_ELEMENTS)) begin
            live = COUNT_W'(MAX_ELEMENTS);
         end
      end
   end

   assign accept    = start && (state_ff == ST_IDLE);
   assign load_ok   = COUNT_W'(req_payload.index) < live;
   assign query_bad = (req_payload.left > req_payload.right)
                      || (COUNT_W'(req_payload.right) >= live);

   assign in_range = pos_ff <= POS_W'(hi_ff);
   assign whole    = (off_ff == '0)
                     && (SPAN_W'(pos_ff) + SPAN_W'(BLOCK_LEN - 1) <= SPAN_W'(hi_ff));
   assign addend   = pend_ff ? (pend_blk_ff ? bsum_rd_ff : elem_rd_ff) : '0;

   assign elem_raddr = (state_ff == ST_WALK) ? AW'(pos_ff) : AW'(req_ff.index);
   assign bsum_raddr = blk_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      csr_in        = csr_we ? csr_wdata : csr_ff;
      req_in        = req_ff;
      pos_in        = pos_ff;
      hi_in         = hi_ff;
      blk_in        = blk_ff;
      off_in        = off_ff;
      acc_in        = acc_ff;
      pend_blk_in   = pend_blk_ff;
      diff_in       = diff_ff;
      rsp_in        = rsp_ff;
      div_go        = 1'b0;
      div_dividend  = (req_payload.mode == MODE_QUERY) ? req_payload.left
                                                       : req_payload.index;
      elem_we       = 1'b0;
      elem_waddr    = AW'(req_ff.index);
      elem_wdata    = req_ff.value;
      bsum_we       = 1'b0;
      bsum_waddr    = blk_ff;
      bsum_wdata    = bsum_rd_ff + diff_ff;

      case (state_ff)
         ST_CLEAR: begin
            elem_we    = 1'b1;
            elem_waddr = clr_ff;
            elem_wdata = '0;
            bsum_we    = {1'b0, clr_ff} < (AW + 1)'(BLOCK_COUNT);
            bsum_waddr = BLK_W'(clr_ff);
            bsum_wdata = '0;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_ELEMENTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in = req_payload;
               if (req_payload.mode == MODE_LOAD) begin
                  // drop loads beyond the count
                  if (load_ok) begin
                     div_go   = 1'b1;
                     state_in = ST_DIV;
                  end
               end else if (query_bad) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_in.range_sum = '0;
                  rsp_in.status    = STATUS_BAD;
               end else begin
                  div_go   = 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               blk_in = BLK_W'(div_quot);
               off_in = OFF_W'(div_rem);
               if (req_ff.mode == MODE_LOAD) begin
                  state_in = ST_LD_RD;
               end else begin
                  pos_in   = POS_W'(req_ff.left);
                  hi_in    = req_ff.right;
                  acc_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_LD_RD: begin
            state_in = ST_LD_DIFF;
         end
         ST_LD_DIFF: begin
            diff_in  = req_ff.value - elem_rd_ff;
            state_in = ST_LD_WR;
         end
         ST_LD_WR: begin
            elem_we  = 1'b1;
            bsum_we  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            // fold in last cycle's read while this cycle's read is issued
            acc_in = acc_ff + addend;
            if (in_range) begin
               pend_in     = 1'b1;
               pend_blk_in = whole;
               if (whole) begin
                  pos_in = pos_ff + POS_W'(BLOCK_LEN);
                  blk_in = blk_ff + BLK_W'(1);
               end else begin
                  pos_in = pos_ff + POS_W'(1);
                  if (off_ff == OFF_W'(BLOCK_LEN - 1)) begin
                     off_in = '0;
                     blk_in = blk_ff + BLK_W'(1);
                  end else begin
                     off_in = off_ff + OFF_W'(1);
                  end
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_in.range_sum = acc_ff;
                  rsp_in.status    = STATUS_OK;
                  state_in         = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         csr_ff        <= COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
         csr_ff        <= csr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pos_ff      <= pos_in;
      hi_ff       <= hi_in;
      blk_ff      <= blk_in;
      off_ff      <= off_in;
      acc_ff      <= acc_in;
      pend_blk_ff <= pend_blk_in;
      diff_ff     <= diff_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_waddr] <= elem_wdata;
      end
      if (bsum_we) begin
         bsum_mem[bsum_waddr] <= bsum_wdata;
      end
      elem_rd_ff <= elem_mem[elem_raddr];
      bsum_rd_ff <= bsum_mem[bsum_raddr];
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/core/bdrs_div.sv]
// Block divider for the range-sum core: splits an element index into block number and
// offset by reciprocal multiplication, quotient first and remainder in the cycle after.
// Uses bdrs_pkg.
module bdrs_div
   import bdrs_pkg::*;
#(
   parameter int BLOCK_LEN = BLOCK_LEN_DEF,
   localparam int REM_W    = $clog2(BLOCK_LEN + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [IDX_W-1:0] dividend,
   output logic             done,
   output logic [IDX_W-1:0] quot,
   output logic [REM_W-1:0] rem
);

   localparam int SHIFT  = IDX_W + $clog2(BLOCK_LEN);
   localparam int RECIP  = ((1 << SHIFT) + BLOCK_LEN - 1) / BLOCK_LEN;
   localparam int PROD_W = 2 * IDX_W + 1;

   logic [IDX_W-1:0]  quot_ff, quot_in;
   logic [IDX_W-1:0]  dvd_ff, dvd_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              stage_ff, stage_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] prod;
   logic [IDX_W-1:0]  back;

   always_comb begin
      quot_in  = quot_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      stage_in = 1'b0;
      done_in  = 1'b0;
      prod     = PROD_W'(dividend) * PROD_W'(RECIP);
      back     = quot_ff * IDX_W'(BLOCK_LEN);
      if (go) begin
         // rounded-up reciprocal is exact over the whole index range
         quot_in  = IDX_W'(prod >> SHIFT);
         dvd_in   = dividend;
         stage_in = 1'b1;
      end else if (stage_ff) begin
         rem_in  = REM_W'(dvd_ff - back);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

[rtl/core/bdrs_chk.sv]
// Port-level checker for the range-sum core, bound to the top level below.
// Uses bdrs_pkg for the payload types and codes.
module bdrs_chk
   import bdrs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);

   // a result only follows a transaction taken last cycle or work in progress
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start && !busy) || $past(busy)))
      else $error("result without a pending transaction");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == STATUS_BAD) |-> (rsp_payload.range_sum == '0))
      else $error("flagged result carries a nonzero sum");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.mode == MODE_LOAD) |=> !rsp_strobe)
      else $error("load produced a result");

   a_reversed_flagged: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.mode == MODE_QUERY
       && req_payload.left > req_payload.right)
      |=> (rsp_strobe && rsp_payload.status == STATUS_BAD))
      else $error("reversed range not flagged on the next cycle");

endmodule

bind block_decomposed_range_sum_core bdrs_chk u_bdrs_chk (.*);

[tb/sv/range_sum_checker.sv]
// Port checker for the block-decomposed range-sum core: tracks the element store
// and the count register, predicts each query answer and compares it on rsp_strobe.
// Depends on bdrs_pkg for the transaction types and field widths.
module range_sum_checker
   import bdrs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_payload,
   input  logic               rsp_strobe,
   input  rsp_type            rsp_payload,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   localparam int DEPTH = MAX_ELEMENTS_DEF;

   logic [DATA_W-1:0]  element_copy [DEPTH];
   logic [COUNT_W-1:0] count_reg;
   rsp_type            expected_sums [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // count in effect: the register limited to the store size
   function automatic int live_count();
      return (count_reg > DEPTH) ? DEPTH : int'(count_reg);
   endfunction

   function automatic logic [DATA_W-1:0] window_total(int lo, int hi);
      logic [DATA_W-1:0] acc;
      int                i;
      acc = '0;
      for (i = lo; i <= hi; i++)
         acc += element_copy[i];
      return acc;
   endfunction

   function automatic void apply_transaction(req_type t);
      int      lim;
      rsp_type r;
      lim = live_count();
      if (t.mode == MODE_LOAD) begin
         // drop loads past the count in effect
         if (int'(t.index) < lim)
            element_copy[t.index] = t.value;
      end else begin
         if (t.left > t.right || int'(t.right) >= lim) begin
            r.range_sum = '0;
            r.status    = STATUS_BAD;
         end else begin
            r.range_sum = window_total(int'(t.left), int'(t.right));
            r.status    = STATUS_OK;
         end
         expected_sums.push_back(r);
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      int      errs;
      int      i;
      errs = 0;
      if (reset) begin
         for (i = 0; i < DEPTH; i++)
            element_copy[i] = '0;
         count_reg = COUNT_RESET;
         expected_sums.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (expected_sums.size() == 0) begin
               $error("result transaction with nothing pending: range_sum %0d status %0d",
                      rsp_payload.range_sum, rsp_payload.status);
               errs++;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_payload.range_sum !== want.range_sum) begin
                  $error("range_sum mismatch: expected %0d, actual %0d",
                         want.range_sum, rsp_payload.range_sum);
                  errs++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_payload.status);
                  errs++;
               end
            end
         end
         // a transaction taken at this edge still sees the old count
         if (start === 1'b1 && busy === 1'b0)
            apply_transaction(req_payload);
         if (csr_we === 1'b1)
            count_reg = csr_wdata;
      end
      fail_count <= fail_count + errs;
      pending    <= expected_sums.size();
   end

endmodule

[tb/sv/tb_block_decomposed_range_sum_core.sv]
// Testbench top for block_decomposed_range_sum_core: clock, reset, directed and
// random load/query transactions, count register writes and the final verdict.
// Depends on bdrs_pkg, the core and range_sum_checker.
module tb_block_decomposed_range_sum_core;
   import bdrs_pkg::*;

   localparam int LOAD_SETTLE     = 24;
   localparam int END_TAIL        = 200;
   localparam int ITEMS_PER_PHASE = 220;
   localparam int ZERO_PHASE      = 20;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic               busy;
   req_type            req_payload = '0;
   logic               rsp_strobe;
   rsp_type            rsp_payload;
   logic               csr_we    = 1'b0;
   logic [COUNT_W-1:0] csr_wdata = '0;
   int                 fail_count;
   int                 pending;
   int                 live_n;

   always #5 clock = ~clock;

   block_decomposed_range_sum_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   range_sum_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // hold the transaction until the core takes it; return at the accepting edge
   task automatic send(input req_type t);
      req_payload <= t;
      start       <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
   endtask

   // drop start, wait for every answer, let a trailing load finish
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
   endtask

   task automatic set_count(input int v);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= COUNT_W'(v);
      @(posedge clock);
      csr_we    <= 1'b0;
      live_n = (v > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : v;
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return DATA_W'($urandom_range(0, 200)) - 32'd100;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type load_item(input int idx, input logic [DATA_W-1:0] v);
      req_type t;
      t.mode  = MODE_LOAD;
      t.index = IDX_W'(idx);
      t.value = v;
      t.left  = IDX_W'($urandom_range(0, 1023));
      t.right = IDX_W'($urandom_range(0, 1023));
      return t;
   endfunction

   function automatic req_type query_item(input int lo, input int hi);
      req_type t;
      t.mode  = MODE_QUERY;
      t.index = IDX_W'($urandom_range(0, 1023));
      t.value = $urandom;
      t.left  = IDX_W'(lo);
      t.right = IDX_W'(hi);
      return t;
   endfunction

   function automatic req_type random_item(input int lim);
      req_type t;
      int      a, b, k;
      if ($urandom_range(0, 99) < 45)
         t = load_item($urandom_range(0, 1023), pick_value());
      else
         t = query_item($urandom_range(0, 1023), $urandom_range(0, 1023));
      if (lim == 0)
         return t;
      if (t.mode == MODE_LOAD) begin
         // mostly in range, now and then past the count
         if ($urandom_range(0, 7) != 0)
            t.index = IDX_W'($urandom_range(0, lim - 1));
      end else begin
         case ($urandom_range(0, 9))
            0: begin
               a = $urandom_range(1, 1023);
               t.left  = IDX_W'(a);
               t.right = IDX_W'($urandom_range(0, a - 1));
            end
            1: begin
               if (lim < MAX_ELEMENTS_DEF) begin
                  b = $urandom_range(lim, 1023);
                  t.right = IDX_W'(b);
                  t.left  = IDX_W'($urandom_range(0, b));
               end else begin
                  a = $urandom_range(1, 1023);
                  t.left  = IDX_W'(a);
                  t.right = IDX_W'($urandom_range(0, a - 1));
               end
            end
            2, 3: begin
               // block-aligned span of one to four blocks, cut off at the count
               k = $urandom_range(0, (lim - 1) / BLOCK_LEN_DEF);
               a = k * BLOCK_LEN_DEF;
               b = a + BLOCK_LEN_DEF * $urandom_range(1, 4) - 1;
               t.left  = IDX_W'(a);
               t.right = IDX_W'((b < lim) ? b : lim - 1);
            end
            default: begin
               a = $urandom_range(0, lim - 1);
               if ($urandom_range(0, 1) == 0) begin
                  b = a + $urandom_range(0, 40);
                  if (b > lim - 1)
                     b = lim - 1;
               end else begin
                  b = $urandom_range(0, lim - 1);
               end
               t.left  = IDX_W'((a < b) ? a : b);
               t.right = IDX_W'((a < b) ? b : a);
            end
         endcase
      end
      return t;
   endfunction

   initial begin : stimulus
      int counts [8];
      int n, remaining, burst, gap, phase, k;
      bit paused;
      counts = '{2047, 37, 1024, 1, 0, 1023, 64, 700};
      counts[7] = $urandom_range(2, 1023);
      paused = 1'b0;
      live_n = MAX_ELEMENTS_DEF;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // hold off until the clearing sweep is over
      while (busy !== 1'b0)
         @(posedge clock);

      // reset count, zeroed store
      send(query_item(0, 1023));
      send(query_item(1023, 1023));

      // count above capacity: limited to the store size
      set_count(2047);
      send(load_item(0, 32'h7FFF_FFFF));
      send(load_item(1023, 32'h8000_0000));
      send(load_item(31, 32'hFFFF_FFFF));
      send(load_item(32, 32'd1));
      send(load_item(0, 32'd5));
      send(load_item(1, 32'h7FFF_FFFF));
      send(query_item(0, 0));
      send(query_item(1023, 1023));
      send(query_item(0, 1023));
      send(query_item(31, 32));
      send(query_item(0, 31));
      send(query_item(1, 1022));
      send(query_item(5, 3));
      send(query_item(1023, 0));

      // zero count: loads dropped, every query flagged
      set_count(0);
      send(load_item(0, 32'd77));
      send(query_item(0, 0));

      set_count(1);
      send(load_item(0, -32'sd9));
      send(load_item(1, 32'd123));
      send(query_item(0, 0));
      send(query_item(0, 1));

      // shrunk count: old elements past it stay, but are out of reach
      set_count(100);
      send(load_item(100, 32'd55));
      send(query_item(90, 99));
      send(query_item(0, 100));
      send(query_item(32, 95));

      for (phase = 0; phase < 8; phase++) begin
         set_count(counts[phase]);
         n = (counts[phase] == 0) ? ZERO_PHASE : ITEMS_PER_PHASE;
         remaining = n;
         while (remaining > 0) begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 7) == 0)
               burst = 40;
            for (k = 0; k < burst && remaining > 0; k++) begin
               send(random_item(live_n));
               remaining--;
            end
            if (remaining > 0) begin
               if (phase == 2 && !paused && remaining < n / 2) begin
                  settle();
                  paused = 1'b1;
               end else begin
                  gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                  if (gap > 0) begin
                     start <= 1'b0;
                     repeat (gap) @(posedge clock);
                  end
               end
            end
         end
      end

      settle();
      repeat (END_TAIL) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASS block_decomposed_range_sum_core");
      else
         $display("FAIL block_decomposed_range_sum_core");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("FAIL block_decomposed_range_sum_core");
      $finish;
   end

endmodule

[files.f]
rtl/core/bdrs_pkg.sv
rtl/core/bdrs_div.sv
rtl/core/block_decomposed_range_sum_core.sv
rtl/core/bdrs_chk.sv
tb/sv/range_sum_checker.sv
tb/sv/tb_block_decomposed_range_sum_core.sv
